@@ rtl/core/lbs_pkg.sv @@
// Package for the LED breathing sweep block.
// Holds the word types, command codes, level constants and the gamma table.
// No dependencies.
package lbs_pkg;

  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 16;
  localparam int DARK_W   = 16;
  localparam int LEVEL_W  = 17;
  localparam int DUTY_W   = 8;

  localparam logic [LEVEL_W-1:0] RAMP_LEVELS = 17'd64;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic                command;
    logic                channel;
    logic [PERIOD_W-1:0] step_period;
    logic [COUNT_W-1:0]  sweep_count;
    logic [DARK_W-1:0]   dark_steps;
  } lbs_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] power_duty;
    logic              power_duty_valid;
    logic [DUTY_W-1:0] status_duty;
    logic              status_duty_valid;
    logic              power_busy;
    logic              status_busy;
  } lbs_out_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              stepped;
    logic              busy;
  } lbs_chan_res_t;

  function automatic logic [DUTY_W-1:0] gamma_of(input logic [4:0] idx);
    logic [DUTY_W-1:0] d;
    case (idx)
      5'd0:  d = 8'd0;
      5'd1:  d = 8'd1;
      5'd2:  d = 8'd2;
      5'd3:  d = 8'd3;
      5'd4:  d = 8'd4;
      5'd5:  d = 8'd5;
      5'd6:  d = 8'd7;
      5'd7:  d = 8'd9;
      5'd8:  d = 8'd12;
      5'd9:  d = 8'd15;
      5'd10: d = 8'd18;
      5'd11: d = 8'd22;
      5'd12: d = 8'd27;
      5'd13: d = 8'd32;
      5'd14: d = 8'd38;
      5'd15: d = 8'd44;
      5'd16: d = 8'd51;
      5'd17: d = 8'd58;
      5'd18: d = 8'd67;
      5'd19: d = 8'd76;
      5'd20: d = 8'd86;
      5'd21: d = 8'd96;
      5'd22: d = 8'd108;
      5'd23: d = 8'd120;
      5'd24: d = 8'd134;
      5'd25: d = 8'd148;
      5'd26: d = 8'd163;
      5'd27: d = 8'd180;
      5'd28: d = 8'd197;
      5'd29: d = 8'd216;
      5'd30: d = 8'd235;
      5'd31: d = 8'd255;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

  // Levels below 32 ramp up, 32 to 63 ramp down, and anything above is dark.
  function automatic logic [DUTY_W-1:0] duty_of_level(input logic [LEVEL_W-1:0] lv);
    logic [4:0] idx;
    idx = lv[5] ? ~lv[4:0] : lv[4:0];
    return (lv >= RAMP_LEVELS) ? '0 : gamma_of(idx);
  endfunction

endpackage

@@ rtl/core/led_breathing_sweep.sv @@
// Top level of the LED breathing sweep: input word register, one
// lbs_channel per LED and the result word register. Depends on lbs_pkg.
// An accepted word goes through the input word register, then the result register.
// Throughput is one word per cycle while out_stall is low; the result register
// frees itself in the cycle its word is taken, so the input side keeps flowing.
// Reset (synchronous, active low) stops every channel and empties both registers.
module led_breathing_sweep #(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbs_pkg::lbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lbs_pkg::lbs_out_t out_data
);
  import lbs_pkg::*;

  lbs_in_t       in_r;
  logic          in_valid_r;
  lbs_out_t      out_r, out_nxt;
  logic          out_valid_r;
  logic          out_ready;
  logic          advance;
  lbs_chan_res_t chan_res [CHANNELS];

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic hit;
    if (c < 2) begin : g_addr
      assign hit = (in_r.channel == 1'(c));
    end else begin : g_noaddr
      assign hit = 1'b0;
    end

    lbs_channel u_chan (
      .clk          (clk),
      .rst_n        (rst_n),
      .tick_en      (advance && (in_r.command == CMD_TICK)),
      .start_en     (advance && (in_r.command == CMD_START) && hit),
      .start_period (in_r.step_period),
      .start_count  (in_r.sweep_count),
      .start_dark   (in_r.dark_steps),
      .res          (chan_res[c])
    );
  end

  always_comb begin
    out_nxt                  = '0;
    out_nxt.power_duty       = chan_res[0].duty;
    out_nxt.power_duty_valid = chan_res[0].stepped;
    out_nxt.power_busy       = chan_res[0].busy;
    if (CHANNELS > 1) begin
      out_nxt.status_duty       = chan_res[CHANNELS > 1 ? 1 : 0].duty;
      out_nxt.status_duty_valid = chan_res[CHANNELS > 1 ? 1 : 0].stepped;
      out_nxt.status_busy       = chan_res[CHANNELS > 1 ? 1 : 0].busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ rtl/core/lbs_channel.sv @@
// One LED channel of the breathing sweep: period, sweep count, dark pause,
// prescaler and level registers with their tick and start update logic.
// Depends on lbs_pkg.
module lbs_channel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_en,
  input  logic                        start_en,
  input  logic [lbs_pkg::PERIOD_W-1:0] start_period,
  input  logic [lbs_pkg::COUNT_W-1:0]  start_count,
  input  logic [lbs_pkg::DARK_W-1:0]   start_dark,
  output lbs_pkg::lbs_chan_res_t      res
);
  import lbs_pkg::*;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [COUNT_W-1:0]  sweeps_r, sweeps_nxt;
  logic [DARK_W-1:0]   dark_r, dark_nxt;
  logic [PERIOD_W-1:0] pre_r, pre_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;

  logic [PERIOD_W:0]   pre_inc;
  logic [LEVEL_W-1:0]  level_inc;
  logic [LEVEL_W-1:0]  wrap_point;
  logic [COUNT_W-1:0]  sweeps_dec;

  assign pre_inc    = {1'b0, pre_r} + 17'd1;
  assign level_inc  = level_r + 17'd1;
  assign wrap_point = RAMP_LEVELS + {1'b0, dark_r};
  assign sweeps_dec = sweeps_r - 16'd1;

  always_comb begin
    period_nxt  = period_r;
    sweeps_nxt  = sweeps_r;
    dark_nxt    = dark_r;
    pre_nxt     = pre_r;
    level_nxt   = level_r;
    res.duty    = '0;
    res.stepped = 1'b0;
    if (tick_en) begin
      if (period_r == '0) begin
        pre_nxt   = '0;
        level_nxt = '0;
      end else if (pre_inc < {1'b0, period_r}) begin
        pre_nxt = pre_inc[PERIOD_W-1:0];
      end else begin
        pre_nxt     = '0;
        res.stepped = 1'b1;
        if (level_inc >= wrap_point) begin
          level_nxt  = '0;
          sweeps_nxt = sweeps_dec;
          if (sweeps_dec == '0) begin
            period_nxt = '0;
          end
        end else begin
          level_nxt = level_inc;
        end
        res.duty = duty_of_level(level_nxt);
      end
    end else if (start_en) begin
      period_nxt = start_period;
      sweeps_nxt = start_count;
      dark_nxt   = start_dark;
    end
    res.busy = (period_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      sweeps_r <= '0;
      dark_r   <= '0;
      pre_r    <= '0;
      level_r  <= '0;
    end else if (tick_en || start_en) begin
      period_r <= period_nxt;
      sweeps_r <= sweeps_nxt;
      dark_r   <= dark_nxt;
      pre_r    <= pre_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

@@ bench/lbs_sweep_checker.sv @@
// Result checker for the LED breathing sweep testbench: watches both word channels,
// predicts each result word from the accepted input words and compares them field by field.
// Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_sweep_checker #(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  lbs_pkg::lbs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  lbs_pkg::lbs_out_t out_data,
  output int                fail_count,
  output int                pending_words
);
  import lbs_pkg::*;

  logic [7:0]  gamma_rom [32];
  logic [15:0] period_q [CHANNELS];
  logic [15:0] sweeps_q [CHANNELS];
  logic [15:0] dark_q [CHANNELS];
  logic [15:0] presc_q [CHANNELS];
  logic [16:0] level_q [CHANNELS];
  lbs_out_t    duty_words_due [$];
  int          results_seen;

  initial begin
    gamma_rom = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd9,
                  8'd12, 8'd15, 8'd18, 8'd22, 8'd27, 8'd32, 8'd38, 8'd44,
                  8'd51, 8'd58, 8'd67, 8'd76, 8'd86, 8'd96, 8'd108, 8'd120,
                  8'd134, 8'd148, 8'd163, 8'd180, 8'd197, 8'd216, 8'd235, 8'd255};
    for (int c = 0; c < CHANNELS; c++) begin
      period_q[c] = '0;
      sweeps_q[c] = '0;
      dark_q[c]   = '0;
      presc_q[c]  = '0;
      level_q[c]  = '0;
    end
    fail_count    = 0;
    pending_words = 0;
    results_seen  = 0;
  end

  function automatic logic [7:0] level_duty(input logic [16:0] lv);
    logic [4:0] fold;
    if (lv >= 17'd64) begin
      return 8'd0;
    end
    fold = (lv < 17'd32) ? lv[4:0] : 5'd31 - lv[4:0];
    return gamma_rom[fold];
  endfunction

  task automatic tick_led(input int c, output logic took_step, output logic [7:0] duty);
    int next_count;
    took_step = 1'b0;
    duty      = '0;
    if (period_q[c] == '0) begin
      presc_q[c] = '0;
      level_q[c] = '0;
    end else begin
      next_count = int'(presc_q[c]) + 1;
      if (next_count < int'(period_q[c])) begin
        presc_q[c] = next_count[15:0];
      end else begin
        presc_q[c] = '0;
        level_q[c] = level_q[c] + 17'd1;
        if (int'(level_q[c]) >= 64 + int'(dark_q[c])) begin
          level_q[c]  = '0;
          sweeps_q[c] = sweeps_q[c] - 16'd1;
          if (sweeps_q[c] == '0) begin
            period_q[c] = '0;
          end
        end
        took_step = 1'b1;
        duty      = level_duty(level_q[c]);
      end
    end
  endtask

  task automatic predict_word(input lbs_in_t w, output lbs_out_t r);
    logic       took;
    logic [7:0] duty;
    int         c;
    r = '0;
    if (w.command == CMD_START) begin
      c = int'(w.channel);
      if (c < CHANNELS) begin
        period_q[c] = w.step_period;
        sweeps_q[c] = w.sweep_count;
        dark_q[c]   = w.dark_steps;
      end
    end else begin
      for (c = 0; c < CHANNELS; c++) begin
        tick_led(c, took, duty);
        if (c == 0 && took) begin
          r.power_duty       = duty;
          r.power_duty_valid = 1'b1;
        end
        if (c == 1 && took) begin
          r.status_duty       = duty;
          r.status_duty_valid = 1'b1;
        end
      end
    end
    r.power_busy  = (period_q[0] != '0);
    r.status_busy = (CHANNELS > 1) ? (period_q[1] != '0) : 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result word %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    lbs_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (duty_words_due.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          want = duty_words_due.pop_front();
          check_field("power_duty", out_data.power_duty, want.power_duty);
          check_field("power_duty_valid", out_data.power_duty_valid, want.power_duty_valid);
          check_field("status_duty", out_data.status_duty, want.status_duty);
          check_field("status_duty_valid", out_data.status_duty_valid,
                      want.status_duty_valid);
          check_field("power_busy", out_data.power_busy, want.power_busy);
          check_field("status_busy", out_data.status_busy, want.status_busy);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_word(in_data, want);
        duty_words_due.push_back(want);
      end
      pending_words <= duty_words_due.size();
    end
  end

endmodule

@@ bench/tb_led_breathing_sweep.sv @@
// Top of the LED breathing sweep testbench: clock, reset, stimulus and receiver stalls.
// Instantiates led_breathing_sweep and lbs_sweep_checker; depends on lbs_pkg.
`timescale 1ns / 1ps

module tb_led_breathing_sweep;
  import lbs_pkg::*;

  localparam int   CHANNELS   = 2;
  localparam int   ITEMS      = 900;
  localparam int   HOLD_OFF   = 200;
  localparam int   LIMIT      = 200000;
  localparam logic LED_POWER  = 1'b0;
  localparam logic LED_STATUS = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lbs_in_t   in_data;
  logic      out_valid;
  logic      out_stall;
  lbs_out_t  out_data;
  int        fail_count;
  int        pending_words;
  int        burst_left = 0;
  int        items_sent = 0;
  int        cycle_count = 0;

  always #5 clk = ~clk;

  led_breathing_sweep #(.CHANNELS(CHANNELS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  lbs_sweep_checker #(.CHANNELS(CHANNELS)) sweep_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  function automatic lbs_in_t tick_word();
    lbs_in_t w;
    w.command     = CMD_TICK;
    w.channel     = 1'($urandom);
    w.step_period = 16'($urandom);
    w.sweep_count = 16'($urandom);
    w.dark_steps  = 16'($urandom);
    return w;
  endfunction

  function automatic lbs_in_t start_word(input logic ch, input logic [15:0] period,
                                         input logic [15:0] sweeps, input logic [15:0] dark);
    lbs_in_t w;
    w.command     = CMD_START;
    w.channel     = ch;
    w.step_period = period;
    w.sweep_count = sweeps;
    w.dark_steps  = dark;
    return w;
  endfunction

  function automatic lbs_in_t random_start();
    lbs_in_t w;
    w = start_word(1'($urandom_range(0, 1)), 16'($urandom_range(1, 3)),
                   16'($urandom_range(1, 2)), 16'($urandom_range(0, 4)));
    case ($urandom_range(0, 19))
      0: w.step_period = 16'd0;
      1: begin
        w.step_period = 16'($urandom);
        w.sweep_count = 16'($urandom);
        w.dark_steps  = 16'($urandom);
      end
      2: w.dark_steps  = 16'($urandom_range(20, 90));
      3: w.sweep_count = 16'd0;
      4: w.step_period = 16'hFFFF;
      5: w.dark_steps  = 16'hFFFF;
      default: ;
    endcase
    return w;
  endfunction

  task automatic offer(input lbs_in_t w);
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    int run_len;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(tick_word());
    offer(start_word(LED_POWER, 16'd1, 16'd1, 16'd0));
    repeat (3) offer(tick_word());
    offer(start_word(LED_STATUS, 16'hFFFF, 16'd0, 16'hFFFF));
    offer(tick_word());
    offer(start_word(LED_STATUS, 16'd2, 16'd2, 16'd2));
    repeat (2) offer(tick_word());
    offer(start_word(LED_POWER, 16'd0, 16'hFFFF, 16'hFFFF));
    repeat (2) offer(tick_word());
    offer(start_word(LED_POWER, 16'd3, 16'd0, 16'd1));
    repeat (3) offer(tick_word());

    while (items_sent < ITEMS) begin
      offer(random_start());
      run_len = $urandom_range(8, 160);
      repeat (run_len) begin
        if ($urandom_range(0, 39) == 0) begin
          offer(random_start());
        end else begin
          offer(tick_word());
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_led_breathing_sweep: clean");
    end else begin
      $display("tb_led_breathing_sweep: errors");
    end
    $finish;
  end

  initial begin
    int seg_len;
    int stall_pct;
    int seg_count;
    out_stall = 1'b0;
    seg_count = 0;
    @(posedge rst_n);
    forever begin
      seg_count++;
      if (seg_count == 6) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_OFF - 1) @(negedge clk);
      end else begin
        seg_len = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        repeat (seg_len) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_led_breathing_sweep: errors");
      $finish;
    end
  end

endmodule
